>>> src/ple_pkg.sv
// Shared types and constants for the positional list engine.
// Defines the operation and status codes and the fixed field widths.
// No dependencies.
package ple_pkg;

  localparam int KindW = 3;
  localparam int PosW  = 9;
  localparam int ValW  = 32;
  localparam int CntW  = 9;

  typedef enum logic [KindW-1:0] {
    K_INSERT = 3'd0,
    K_REMOVE = 3'd1,
    K_READ   = 3'd2,
    K_WRITE  = 3'd3,
    K_SEARCH = 3'd4,
    K_CLEAR  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

>>> src/positional_list_engine_core.sv
// Positional list engine: ordered list of signed 32-bit values in a single-port-pair memory.
// Insert/remove shift entries one per cycle; search scans one entry per cycle.
// Depends on ple_pkg for field widths, operation and status codes.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------------------
//   in      | input     | in_valid, in_stall, in_kind, in_position, in_value
//   out     | output    | out_valid, out_stall, out_read_value, out_found_position,
//           |           | out_status, out_count
//
// Steps per transaction: each is checked in the start state and its result loaded from the done
// state; a read passes through a read state, insert and remove shift the entries between the
// position and the tail, and search scans from the head up to the first match or the count,
// paced by the one read and one write the list memory allows per cycle.
// One transaction is in work at a time; in_stall is high from acceptance until the result
// is loaded into the output register. A stalled result is held in the output register
// while the next transaction is accepted. Reset clears the count and control state only;
// the memory needs no clearing pass since only written entries are ever read.
module positional_list_engine_core #(
  parameter int CAPACITY = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ple_pkg::KindW-1:0]       in_kind,
  input  logic [ple_pkg::PosW-1:0]        in_position,
  input  logic signed [ple_pkg::ValW-1:0] in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [ple_pkg::ValW-1:0] out_read_value,
  output logic signed [ple_pkg::PosW-1:0] out_found_position,
  output ple_pkg::status_t                out_status,
  output logic [ple_pkg::CntW-1:0]        out_count
);
  import ple_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > PosW) ? CW : PosW;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SCAN,
    S_READ,
    S_DONE
  } state_t;

  // list storage
  logic [ValW-1:0] mem [CAPACITY];
  logic [ValW-1:0] rdata_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_wa, mem_ra;
  logic [ValW-1:0] mem_wd;

  state_t          state_r, state_nxt;
  kind_t           kind_r, kind_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [ValW-1:0] val_r, val_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   cur_r, cur_nxt;
  logic [CW-1:0]   wa_r, wa_nxt;
  logic            pend_r, pend_nxt;
  logic [ValW-1:0] res_rd_r, res_rd_nxt;
  logic [PosW-1:0] res_found_r, res_found_nxt;
  status_t         res_status_r, res_status_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [ValW-1:0] out_rd_r, out_rd_nxt;
  logic [PosW-1:0] out_found_r, out_found_nxt;
  status_t         out_status_r, out_status_nxt;
  logic [CntW-1:0] out_count_r, out_count_nxt;

  logic            accept;
  logic [XW-1:0]   pos_x, n_x;
  logic [CW-1:0]   pos_c;

  assign in_stall = (state_r != S_IDLE) || !rst_n;
  assign accept   = in_valid && !in_stall;
  assign pos_x    = XW'(pos_r);
  assign n_x      = XW'(n_r);
  assign pos_c    = CW'(pos_r);

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    n_nxt          = n_r;
    cur_nxt        = cur_r;
    wa_nxt         = wa_r;
    pend_nxt       = pend_r;
    res_rd_nxt     = res_rd_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_rd_nxt     = out_rd_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_wa         = wa_r[AW-1:0];
    mem_wd         = rdata_r;
    mem_re         = 1'b0;
    mem_ra         = cur_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt  = kind_t'(in_kind);
          pos_nxt   = in_position;
          val_nxt   = in_value;
          state_nxt = S_START;
        end
      end
      S_START: begin
        res_rd_nxt     = '0;
        res_found_nxt  = '0;
        res_status_nxt = ST_OK;
        pend_nxt       = 1'b0;
        state_nxt      = S_DONE;
        case (kind_r)
          K_INSERT: begin
            if (pos_x > n_x) begin
              res_status_nxt = ST_BADPOS;
            end else if (n_r == CapC) begin
              res_status_nxt = ST_FULL;
            end else begin
              cur_nxt   = n_r;
              state_nxt = S_SHIFT_UP;
            end
          end
          K_REMOVE: begin
            if (pos_x >= n_x) begin
              res_status_nxt = ST_BADPOS;
            end else begin
              cur_nxt   = CW'(pos_c + 1'b1);
              state_nxt = S_SHIFT_DN;
            end
          end
          K_READ: begin
            if (pos_x >= n_x) begin
              res_status_nxt = ST_BADPOS;
            end else begin
              mem_re    = 1'b1;
              mem_ra    = pos_c[AW-1:0];
              state_nxt = S_READ;
            end
          end
          K_WRITE: begin
            if (pos_x >= n_x) begin
              res_status_nxt = ST_BADPOS;
            end else begin
              mem_we = 1'b1;
              mem_wa = pos_c[AW-1:0];
              mem_wd = val_r;
            end
          end
          K_SEARCH: begin
            cur_nxt   = '0;
            state_nxt = S_SCAN;
          end
          K_CLEAR: begin
            n_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_SHIFT_UP: begin
        // move entry cur-1 to cur, walking down toward the insert position
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (cur_r > pos_c) begin
          mem_re   = 1'b1;
          mem_ra   = AW'(cur_r - 1'b1);
          wa_nxt   = cur_r;
          cur_nxt  = CW'(cur_r - 1'b1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            mem_we    = 1'b1;
            mem_wa    = pos_c[AW-1:0];
            mem_wd    = val_r;
            n_nxt     = CW'(n_r + 1'b1);
            state_nxt = S_DONE;
          end
        end
      end
      S_SHIFT_DN: begin
        // move entry cur to cur-1, walking up toward the tail
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (cur_r < n_r) begin
          mem_re   = 1'b1;
          wa_nxt   = CW'(cur_r - 1'b1);
          cur_nxt  = CW'(cur_r + 1'b1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            n_nxt     = CW'(n_r - 1'b1);
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (pend_r && (rdata_r == val_r)) begin
          pend_nxt       = 1'b0;
          res_found_nxt  = PosW'(wa_r);
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end else if (cur_r < n_r) begin
          mem_re   = 1'b1;
          wa_nxt   = cur_r;
          cur_nxt  = CW'(cur_r + 1'b1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            res_found_nxt  = {PosW{1'b1}};
            res_status_nxt = ST_NOTFOUND;
            state_nxt      = S_DONE;
          end
        end
      end
      S_READ: begin
        res_rd_nxt = rdata_r;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_rd_nxt     = res_rd_r;
          out_found_nxt  = res_found_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = CntW'(n_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    wa_r         <= wa_nxt;
    res_rd_r     <= res_rd_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_value     = out_rd_r;
  assign out_found_position = out_found_r;
  assign out_status         = out_status_r;
  assign out_count          = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CapC)
    else $error("element count exceeds capacity");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("memory written while idle");

  a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_SHIFT_UP || state_r == S_SHIFT_DN || state_r == S_SCAN))
    else $error("pending read outside a walk");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside the done state");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("read and write to the same entry in one cycle");

endmodule

>>> test/positional_list_engine_core_test.sv
// Self-checking testbench for positional_list_engine_core: directed and random list operations.
// A shadow copy of the list predicts each result; random idling and stalls, a receiver hold-off.
// Depends on ple_pkg and positional_list_engine_core.
module positional_list_engine_core_test;
  import ple_pkg::*;

  localparam int Depth      = 256;
  localparam int HoldCycles = 600;
  localparam logic [KindW-1:0] KindSpareLo = 3'd6;
  localparam logic [KindW-1:0] KindSpareHi = 3'd7;

  typedef struct {
    logic signed [ValW-1:0] read_value;
    logic [PosW-1:0]        found_position;
    status_t                status;
    logic [CntW-1:0]        count;
  } list_result_t;

  // Shadow of the list: applies each accepted operation and queues the result it must give.
  class list_shadow;
    logic [ValW-1:0] cells [Depth];
    int unsigned     length;
    list_result_t    pending [$];
    int unsigned     mismatches;

    function void note_op(logic [KindW-1:0] kind, logic [PosW-1:0] pos, logic [ValW-1:0] val);
      list_result_t want;
      int unsigned p;
      int i;
      p = pos;
      want.read_value     = '0;
      want.found_position = '0;
      want.status         = ST_OK;
      case (kind)
        K_INSERT: begin
          if (p > length) want.status = ST_BADPOS;
          else if (length >= Depth) want.status = ST_FULL;
          else begin
            for (i = length; i > p; i--) cells[i] = cells[i-1];
            cells[p] = val;
            length++;
          end
        end
        K_REMOVE: begin
          if (p >= length) want.status = ST_BADPOS;
          else begin
            for (i = p; i + 1 < length; i++) cells[i] = cells[i+1];
            length--;
          end
        end
        K_READ: begin
          if (p >= length) want.status = ST_BADPOS;
          else want.read_value = cells[p];
        end
        K_WRITE: begin
          if (p >= length) want.status = ST_BADPOS;
          else cells[p] = val;
        end
        K_SEARCH: begin
          want.status         = ST_NOTFOUND;
          want.found_position = '1;
          for (i = 0; i < length; i++) begin
            if (cells[i] == val) begin
              want.found_position = PosW'(i);
              want.status         = ST_OK;
              break;
            end
          end
        end
        K_CLEAR: length = 0;
        default: ;
      endcase
      want.count = CntW'(length);
      pending.push_back(want);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (pending.size() == 0) begin
        $error("result with no operation outstanding: read_value %0d status %0d count %0d",
               got.read_value, got.status, got.count);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
        mismatches++;
      end
      if (got.found_position !== want.found_position) begin
        $error("found_position: expected %0d, got %0d",
               $signed(want.found_position), $signed(got.found_position));
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  logic [KindW-1:0]       in_kind     = '0;
  logic [PosW-1:0]        in_position = '0;
  logic signed [ValW-1:0] in_value    = '0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  logic signed [ValW-1:0] out_read_value;
  logic signed [PosW-1:0] out_found_position;
  status_t                out_status;
  logic [CntW-1:0]        out_count;

  list_shadow  shadow    = new();
  bit          calm      = 1'b0;
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  positional_list_engine_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_status         (out_status),
    .out_count          (out_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random stalls, none while calm, and a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 21);
    end
  end

  always @(posedge clk) begin
    list_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.read_value     = out_read_value;
      got.found_position = out_found_position;
      got.status         = out_status;
      got.count          = out_count;
      shadow.check_result(got);
    end
  end

  task automatic offer(logic [KindW-1:0] kind, logic [PosW-1:0] pos, logic [ValW-1:0] val);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.note_op(kind, pos, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '1;
      3, 4, 5: return $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  // One random operation; keep the list at or below max_len by turning inserts into removes.
  task automatic random_op(int unsigned max_len);
    int unsigned n;
    int unsigned roll;
    int unsigned p;
    logic [KindW-1:0] kind;
    logic [ValW-1:0]  val;
    n    = shadow.length;
    roll = $urandom_range(99);
    if (roll < 32)      kind = (n >= max_len) ? K_REMOVE : K_INSERT;
    else if (roll < 50) kind = K_REMOVE;
    else if (roll < 64) kind = K_READ;
    else if (roll < 75) kind = K_WRITE;
    else if (roll < 92) kind = K_SEARCH;
    else if (roll < 94) kind = K_CLEAR;
    else                kind = $urandom_range(1) ? KindSpareLo : KindSpareHi;
    roll = $urandom_range(99);
    if (roll < 85) begin
      if (kind == K_INSERT) p = $urandom_range(n);
      else p = (n == 0) ? 0 : $urandom_range(n - 1);
    end else if (roll < 93) begin
      p = n + $urandom_range(3);
    end else begin
      p = $urandom_range(511);
    end
    val = pick_value();
    // hit stored values most of the time, anywhere in the list
    if (kind == K_SEARCH && n != 0 && $urandom_range(99) < 70)
      val = shadow.cells[$urandom_range(n - 1)];
    offer(kind, PosW'(p), val);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: every addressed operation is out of range
    offer(K_CLEAR, 0, 0);
    offer(K_READ, 0, 0);
    offer(K_REMOVE, 0, 0);
    offer(K_WRITE, 0, 32'h1234_5678);
    offer(K_SEARCH, 0, 0);
    offer(K_INSERT, 1, 7);
    // build [-1, min, 0, max] with inserts at head, tail and middle
    offer(K_INSERT, 0, 32'h8000_0000);
    offer(K_INSERT, 1, 32'h7fff_ffff);
    offer(K_INSERT, 0, 32'hffff_ffff);
    offer(K_INSERT, 2, 0);
    offer(K_READ, 0, 0);
    offer(K_READ, 3, 0);
    offer(K_READ, 4, 0);
    offer(K_WRITE, 3, 5);
    offer(K_SEARCH, 511, 5);
    offer(K_SEARCH, 0, 32'h7fff_ffff);
    offer(K_REMOVE, 3, 0);
    offer(K_REMOVE, 0, 0);
    offer(K_INSERT, 511, 9);
    offer(K_READ, 511, 0);
    offer(KindSpareLo, 0, 3);
    offer(KindSpareHi, 511, 32'hffff_ffff);
    offer(K_CLEAR, 0, 0);
    // stale cells past the count must not match
    offer(K_SEARCH, 0, 0);

    repeat (300) random_op(24);
    drain();

    calm <= 1'b1;
    repeat (120) random_op(64);
    calm <= 1'b0;

    // hold the receiver off while the sender keeps offering
    hold_req <= hold_req + 1;
    repeat (12) random_op(64);
    drain();

    // fill the store, mostly appending
    while (shadow.length < Depth) begin
      if ($urandom_range(99) < 10)
        offer(K_INSERT, PosW'($urandom_range(shadow.length)), pick_value());
      else offer(K_INSERT, PosW'(shadow.length), pick_value());
    end
    offer(K_INSERT, PosW'(Depth), 1);
    offer(K_INSERT, 0, 1);
    offer(K_INSERT, PosW'(Depth + 1), 1);
    offer(K_READ, PosW'(Depth - 1), 0);
    offer(K_READ, PosW'(Depth), 0);
    offer(K_SEARCH, 0, shadow.cells[Depth - 1]);
    repeat (50) random_op(Depth);

    offer(K_CLEAR, 0, 0);
    repeat (250) random_op(48);

    drain();
    repeat (300) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("positional_list_engine_core_test: PASS");
    end else begin
      $display("positional_list_engine_core_test: FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("positional_list_engine_core_test: FAIL");
    $finish;
  end

endmodule

>>> sim.f
src/ple_pkg.sv
src/positional_list_engine_core.sv
test/positional_list_engine_core_test.sv
